// ===== rtl/core/strongly_connected_components_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the strongly connected components block
// Concurrent checks on clk_i, with or without the reset disable.
// ----------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH

`ifndef SYNTHESIS
`define SCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCC_ASSERT(name, prop, msg)
`define SCC_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the strongly connected components block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scc_pkg;

  localparam int VTX_W = 6;
  localparam int CFG_W = 7;
  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_PUSH,
    ST_SCAN,
    ST_EDGE,
    ST_CMP,
    ST_FIN,
    ST_POPRD,
    ST_POPWR,
    ST_RET,
    ST_PAR1,
    ST_PAR2,
    ST_E_FIND,
    ST_E_ROOT,
    ST_E_SCAN,
    ST_E_CHK
  } state_e;

  typedef struct packed {
    logic add;
    logic clear;
    logic rd;
  } es_ctl_t;

  typedef struct packed {
    logic             clear;
    logic             push_walk;
    logic             push_comp;
    logic             pop_walk;
    logic             pop_comp;
    logic [VTX_W-1:0] data;
  } stk_req_t;

endpackage

// ===== rtl/core/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Edge loader and component search over a directed graph in on-chip memory.
//
//   channel   handshake              payload
//   command   start / busy           command_i, edge_from_i, edge_to_i
//   result    result_valid_o strobe  vertex_o, component_index_o,
//                                    component_end_o, overflow_o, last_o
//   config    num_vertices_we_i      num_vertices_i
//
// Add and clear are done from idle without raising busy. A run over the stored
// edges scans them for each vertex (one edge memory read per step, a vertex
// memory read on edges to vertices still on the stack), then orders the results.
// The vertex memory and the stack memory are read through registers.
// Reset clears counters and flags; memories need no clearing pass.
// Results cannot be stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strongly_connected_components #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [scc_pkg::CMD_W-1:0] command_i,
  input  logic [scc_pkg::VTX_W-1:0] edge_from_i,
  input  logic [scc_pkg::VTX_W-1:0] edge_to_i,
  input  logic                      num_vertices_we_i,
  input  logic [scc_pkg::CFG_W-1:0] num_vertices_i,
  output logic                      result_valid_o,
  output logic [scc_pkg::VTX_W-1:0] vertex_o,
  output logic [scc_pkg::VTX_W-1:0] component_index_o,
  output logic                      component_end_o,
  output logic                      overflow_o,
  output logic                      last_o
);
  import scc_pkg::*;

  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int ECW  = $clog2(MAX_EDGES + 1);

  logic [CFG_W-1:0] num_q;
  logic [CNTW-1:0]  n_eff;
  es_ctl_t          es_ctl;
  logic [ECW-1:0]   es_addr, es_cnt;
  logic             es_ovf;
  logic [VTX_W-1:0] es_from, es_to;
  stk_req_t         stk_req;
  logic             stk_walk_empty;
  logic [VTX_W-1:0] stk_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 7'd64;
    end else if (num_vertices_we_i) begin
      num_q <= num_vertices_i;
    end
  end

  assign n_eff = (num_q == '0) ? CNTW'(1) :
                 (num_q > CFG_W'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : CNTW'(num_q);

  scc_edge_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_edges (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (es_ctl),
    .from_i   (edge_from_i),
    .to_i     (edge_to_i),
    .n_eff_i  (n_eff),
    .rd_addr_i(es_addr),
    .cnt_o    (es_cnt),
    .ovf_o    (es_ovf),
    .rd_from_o(es_from),
    .rd_to_o  (es_to)
  );

  scc_stack #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (stk_req),
    .walk_empty_o(stk_walk_empty),
    .rd_o        (stk_rd)
  );

  scc_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .command_i        (command_i),
    .busy_o           (busy),
    .n_eff_i          (n_eff),
    .es_ctl_o         (es_ctl),
    .es_addr_o        (es_addr),
    .es_cnt_i         (es_cnt),
    .es_ovf_i         (es_ovf),
    .es_from_i        (es_from),
    .es_to_i          (es_to),
    .stk_req_o        (stk_req),
    .stk_walk_empty_i (stk_walk_empty),
    .stk_rd_i         (stk_rd),
    .result_valid_o   (result_valid_o),
    .vertex_o         (vertex_o),
    .component_index_o(component_index_o),
    .component_end_o  (component_end_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

endmodule

// ===== rtl/core/scc_edge_store.sv =====
// ----------------------------------------------------------------------------
// scc_edge_store
// Edge memory with fill count and sticky overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scc_edge_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scc_pkg::es_ctl_t                      ctl_i,
  input  logic [scc_pkg::VTX_W-1:0]             from_i,
  input  logic [scc_pkg::VTX_W-1:0]             to_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]     n_eff_i,
  input  logic [$clog2(MAX_EDGES+1)-1:0]        rd_addr_i,
  output logic [$clog2(MAX_EDGES+1)-1:0]        cnt_o,
  output logic                                  ovf_o,
  output logic [scc_pkg::VTX_W-1:0]             rd_from_o,
  output logic [scc_pkg::VTX_W-1:0]             rd_to_o
);
  import scc_pkg::*;

  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [ECW-1:0]       cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic                 wr_en;
  logic [2*VTX_W-1:0]   mem_q [MAX_EDGES];
  logic [2*VTX_W-1:0]   rd_q;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    wr_en = 1'b0;
    if (ctl_i.clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (ctl_i.add) begin
      if ((cnt_q >= ECW'(MAX_EDGES)) || (CFG_W'(from_i) >= CFG_W'(n_eff_i)) ||
          (CFG_W'(to_i) >= CFG_W'(n_eff_i))) begin
        ovf_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        cnt_d = cnt_q + ECW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[EAW-1:0]] <= {from_i, to_i};
    end
    if (ctl_i.rd) begin
      rd_q <= mem_q[rd_addr_i[EAW-1:0]];
    end
  end

  assign cnt_o     = cnt_q;
  assign ovf_o     = ovf_q;
  assign rd_from_o = rd_q[2*VTX_W-1:VTX_W];
  assign rd_to_o   = rd_q[VTX_W-1:0];

endmodule

// ===== rtl/core/scc_stack.sv =====
// ----------------------------------------------------------------------------
// scc_stack
// Walk stack and component stack in one memory, with a registered read on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scc_stack #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  scc_pkg::stk_req_t         req_i,
  output logic                      walk_empty_o,
  output logic [scc_pkg::VTX_W-1:0] rd_o
);
  import scc_pkg::*;

  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int VIW  = $clog2(MAX_VERTICES);

  logic [CNTW-1:0]  wsp_q, csp_q;
  logic [CNTW-1:0]  wsp_m1, csp_m1;
  logic [VTX_W-1:0] mem_q [2*MAX_VERTICES];
  logic [VTX_W-1:0] rd_q;

  assign wsp_m1 = wsp_q - CNTW'(1);
  assign csp_m1 = csp_q - CNTW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsp_q <= '0;
      csp_q <= '0;
    end else if (req_i.clear) begin
      wsp_q <= '0;
      csp_q <= '0;
    end else begin
      if (req_i.push_walk) begin
        wsp_q <= wsp_q + CNTW'(1);
      end else if (req_i.pop_walk) begin
        wsp_q <= wsp_m1;
      end
      if (req_i.push_comp) begin
        csp_q <= csp_q + CNTW'(1);
      end else if (req_i.pop_comp) begin
        csp_q <= csp_m1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push_walk) begin
      mem_q[{1'b0, wsp_q[VIW-1:0]}] <= req_i.data;
    end else if (req_i.push_comp) begin
      mem_q[{1'b1, csp_q[VIW-1:0]}] <= req_i.data;
    end
    if (req_i.pop_walk) begin
      rd_q <= mem_q[{1'b0, wsp_m1[VIW-1:0]}];
    end else if (req_i.pop_comp) begin
      rd_q <= mem_q[{1'b1, csp_m1[VIW-1:0]}];
    end
  end

  assign walk_empty_o = (wsp_q == '0);
  assign rd_o         = rd_q;

endmodule

// ===== rtl/core/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Search sequencer with vertex memory, and ordered result emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "strongly_connected_components_defines.svh"

module scc_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [scc_pkg::CMD_W-1:0]         command_i,
  output logic                              busy_o,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] n_eff_i,
  output scc_pkg::es_ctl_t                  es_ctl_o,
  output logic [$clog2(MAX_EDGES+1)-1:0]    es_addr_o,
  input  logic [$clog2(MAX_EDGES+1)-1:0]    es_cnt_i,
  input  logic                              es_ovf_i,
  input  logic [scc_pkg::VTX_W-1:0]         es_from_i,
  input  logic [scc_pkg::VTX_W-1:0]         es_to_i,
  output scc_pkg::stk_req_t                 stk_req_o,
  input  logic                              stk_walk_empty_i,
  input  logic [scc_pkg::VTX_W-1:0]         stk_rd_i,
  output logic                              result_valid_o,
  output logic [scc_pkg::VTX_W-1:0]         vertex_o,
  output logic [scc_pkg::VTX_W-1:0]         component_index_o,
  output logic                              component_end_o,
  output logic                              overflow_o,
  output logic                              last_o
);
  import scc_pkg::*;

  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int VIW  = $clog2(MAX_VERTICES);
  localparam int ECW  = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic [VTX_W-1:0] comp;
    logic [CNTW-1:0]  low;
    logic [CNTW-1:0]  disc;
    logic [ECW-1:0]   pos;
  } vent_t;

  state_e                  state_q, state_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  logic [CNTW-1:0]         root_q, root_d;
  logic [VTX_W-1:0]        cur_v_q, cur_v_d;
  logic [CNTW-1:0]         cur_disc_q, cur_disc_d;
  logic [CNTW-1:0]         cur_low_q, cur_low_d;
  logic [ECW-1:0]          cur_pos_q, cur_pos_d;
  logic [VTX_W-1:0]        ncomp_q, ncomp_d;
  logic [MAX_VERTICES-1:0] disc_vld_q, disc_vld_d;
  logic [MAX_VERTICES-1:0] on_stk_q, on_stk_d;
  logic [CNTW-1:0]         r_q, r_d;
  logic [CNTW-1:0]         sv_q, sv_d;
  logic [VTX_W-1:0]        comp_c_q, comp_c_d;
  logic [VTX_W-1:0]        rank_q, rank_d;
  logic [CNTW-1:0]         emit_cnt_q, emit_cnt_d;
  logic [VTX_W-1:0]        pend_v_q, pend_v_d;
  logic                    pend_vld_q, pend_vld_d;
  logic                    out_vld_q, out_vld_d;
  logic [VTX_W-1:0]        out_v_q, out_v_d;
  logic [VTX_W-1:0]        out_idx_q, out_idx_d;
  logic                    out_end_q, out_end_d;
  logic                    out_ovf_q, out_ovf_d;
  logic                    out_last_q, out_last_d;

  logic                    disc_go;
  logic [VTX_W-1:0]        disc_vtx;
  logic                    vm_we, vm_re;
  logic [VIW-1:0]          vm_wa, vm_ra;
  vent_t                   vm_wd;
  vent_t                   vm_q [MAX_VERTICES];
  vent_t                   vm_rd_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    root_d     = root_q;
    cur_v_d    = cur_v_q;
    cur_disc_d = cur_disc_q;
    cur_low_d  = cur_low_q;
    cur_pos_d  = cur_pos_q;
    ncomp_d    = ncomp_q;
    disc_vld_d = disc_vld_q;
    on_stk_d   = on_stk_q;
    r_d        = r_q;
    sv_d       = sv_q;
    comp_c_d   = comp_c_q;
    rank_d     = rank_q;
    emit_cnt_d = emit_cnt_q;
    pend_v_d   = pend_v_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = 1'b0;
    out_v_d    = out_v_q;
    out_idx_d  = out_idx_q;
    out_end_d  = out_end_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    es_ctl_o   = '0;
    es_addr_o  = cur_pos_q;
    stk_req_o  = '0;
    disc_go    = 1'b0;
    disc_vtx   = '0;
    vm_we      = 1'b0;
    vm_wa      = cur_v_q[VIW-1:0];
    vm_wd      = '0;
    vm_re      = 1'b0;
    vm_ra      = es_to_i[VIW-1:0];
    busy_o     = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_ADD: es_ctl_o.add = 1'b1;
            CMD_CLEAR: es_ctl_o.clear = 1'b1;
            CMD_RUN: begin
              disc_vld_d      = '0;
              on_stk_d        = '0;
              cnt_d           = '0;
              root_d          = '0;
              ncomp_d         = '0;
              stk_req_o.clear = 1'b1;
              state_d         = ST_ROOT;
            end
            default: ;
          endcase
        end
      end
      ST_ROOT: begin
        if (root_q == n_eff_i) begin
          r_d        = '0;
          rank_d     = '0;
          emit_cnt_d = '0;
          pend_vld_d = 1'b0;
          state_d    = ST_E_FIND;
        end else if (disc_vld_q[root_q[VIW-1:0]]) begin
          root_d = root_q + CNTW'(1);
        end else begin
          disc_go  = 1'b1;
          disc_vtx = VTX_W'(root_q);
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        stk_req_o.push_comp = 1'b1;
        stk_req_o.data      = cur_v_q;
        state_d             = ST_SCAN;
      end
      ST_SCAN: begin
        if (cur_pos_q == es_cnt_i) begin
          state_d = ST_FIN;
        end else begin
          es_ctl_o.rd = 1'b1;
          cur_pos_d   = cur_pos_q + ECW'(1);
          state_d     = ST_EDGE;
        end
      end
      ST_EDGE: begin
        state_d = ST_SCAN;
        if ((es_from_i == cur_v_q) && (CFG_W'(es_to_i) < CFG_W'(n_eff_i))) begin
          if (!disc_vld_q[es_to_i[VIW-1:0]]) begin
            vm_we               = 1'b1;
            vm_wd.low           = cur_low_q;
            vm_wd.disc          = cur_disc_q;
            vm_wd.pos           = cur_pos_q;
            stk_req_o.push_walk = 1'b1;
            stk_req_o.data      = cur_v_q;
            disc_go             = 1'b1;
            disc_vtx            = es_to_i;
            state_d             = ST_PUSH;
          end else if (on_stk_q[es_to_i[VIW-1:0]] && (es_to_i != cur_v_q)) begin
            vm_re   = 1'b1;
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (vm_rd_q.disc < cur_low_q) begin
          cur_low_d = vm_rd_q.disc;
        end
        state_d = ST_SCAN;
      end
      ST_FIN: begin
        vm_we      = 1'b1;
        vm_wd.low  = cur_low_q;
        vm_wd.disc = cur_disc_q;
        vm_wd.pos  = cur_pos_q;
        state_d    = (cur_low_q == cur_disc_q) ? ST_POPRD : ST_RET;
      end
      ST_POPRD: begin
        stk_req_o.pop_comp = 1'b1;
        state_d            = ST_POPWR;
      end
      ST_POPWR: begin
        on_stk_d[stk_rd_i[VIW-1:0]] = 1'b0;
        vm_we                       = 1'b1;
        vm_wa                       = stk_rd_i[VIW-1:0];
        vm_wd.comp                  = ncomp_q;
        if (stk_rd_i == cur_v_q) begin
          ncomp_d = ncomp_q + VTX_W'(1);
          state_d = ST_RET;
        end else begin
          state_d = ST_POPRD;
        end
      end
      ST_RET: begin
        if (stk_walk_empty_i) begin
          root_d  = root_q + CNTW'(1);
          state_d = ST_ROOT;
        end else begin
          stk_req_o.pop_walk = 1'b1;
          state_d            = ST_PAR1;
        end
      end
      ST_PAR1: begin
        cur_v_d = stk_rd_i;
        vm_re   = 1'b1;
        vm_ra   = stk_rd_i[VIW-1:0];
        state_d = ST_PAR2;
      end
      ST_PAR2: begin
        cur_disc_d = vm_rd_q.disc;
        cur_pos_d  = vm_rd_q.pos;
        cur_low_d  = (cur_low_q < vm_rd_q.low) ? cur_low_q : vm_rd_q.low;
        state_d    = ST_SCAN;
      end
      ST_E_FIND: begin
        if (r_q == n_eff_i) begin
          state_d = ST_IDLE;
        end else if (disc_vld_q[r_q[VIW-1:0]]) begin
          vm_re   = 1'b1;
          vm_ra   = r_q[VIW-1:0];
          state_d = ST_E_ROOT;
        end else begin
          r_d = r_q + CNTW'(1);
        end
      end
      ST_E_ROOT: begin
        comp_c_d = vm_rd_q.comp;
        sv_d     = r_q;
        state_d  = ST_E_SCAN;
      end
      ST_E_SCAN: begin
        if (sv_q == n_eff_i) begin
          out_vld_d  = 1'b1;
          out_v_d    = pend_v_q;
          out_idx_d  = rank_q;
          out_end_d  = 1'b1;
          out_ovf_d  = es_ovf_i;
          out_last_d = (emit_cnt_q + CNTW'(1) == n_eff_i);
          emit_cnt_d = emit_cnt_q + CNTW'(1);
          rank_d     = rank_q + VTX_W'(1);
          pend_vld_d = 1'b0;
          state_d    = (emit_cnt_q + CNTW'(1) == n_eff_i) ? ST_IDLE : ST_E_FIND;
        end else begin
          vm_re   = 1'b1;
          vm_ra   = sv_q[VIW-1:0];
          state_d = ST_E_CHK;
        end
      end
      ST_E_CHK: begin
        if (vm_rd_q.comp == comp_c_q) begin
          disc_vld_d[sv_q[VIW-1:0]] = 1'b0;
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_v_d    = pend_v_q;
            out_idx_d  = rank_q;
            out_end_d  = 1'b0;
            out_ovf_d  = es_ovf_i;
            out_last_d = 1'b0;
            emit_cnt_d = emit_cnt_q + CNTW'(1);
          end
          pend_v_d   = VTX_W'(sv_q);
          pend_vld_d = 1'b1;
        end
        sv_d    = sv_q + CNTW'(1);
        state_d = ST_E_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase

    if (disc_go) begin
      cnt_d                          = cnt_q + CNTW'(1);
      cur_v_d                        = disc_vtx;
      cur_disc_d                     = cnt_q + CNTW'(1);
      cur_low_d                      = cnt_q + CNTW'(1);
      cur_pos_d                      = '0;
      disc_vld_d[disc_vtx[VIW-1:0]]  = 1'b1;
      on_stk_d[disc_vtx[VIW-1:0]]    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      root_q     <= '0;
      ncomp_q    <= '0;
      disc_vld_q <= '0;
      on_stk_q   <= '0;
      r_q        <= '0;
      sv_q       <= '0;
      rank_q     <= '0;
      emit_cnt_q <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      root_q     <= root_d;
      ncomp_q    <= ncomp_d;
      disc_vld_q <= disc_vld_d;
      on_stk_q   <= on_stk_d;
      r_q        <= r_d;
      sv_q       <= sv_d;
      rank_q     <= rank_d;
      emit_cnt_q <= emit_cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_v_q    <= cur_v_d;
    cur_disc_q <= cur_disc_d;
    cur_low_q  <= cur_low_d;
    cur_pos_q  <= cur_pos_d;
    comp_c_q   <= comp_c_d;
    pend_v_q   <= pend_v_d;
    out_v_q    <= out_v_d;
    out_idx_q  <= out_idx_d;
    out_end_q  <= out_end_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vm_q[vm_wa] <= vm_wd;
    end
    if (vm_re) begin
      vm_rd_q <= vm_q[vm_ra];
    end
  end

  assign result_valid_o    = out_vld_q;
  assign vertex_o          = out_v_q;
  assign component_index_o = out_idx_q;
  assign component_end_o   = out_end_q;
  assign overflow_o        = out_ovf_q;
  assign last_o            = out_last_q;

  `SCC_ASSERT(a_out_from_emit, out_vld_q |-> ($past(state_q) == ST_E_SCAN || $past(state_q) == ST_E_CHK), "result item outside emit phase")
  `SCC_ASSERT(a_last_ends_run, (out_vld_q && out_last_q) |-> (state_q == ST_IDLE), "run still active after final item")
  `SCC_ASSERT(a_end_with_last, (out_vld_q && out_last_q) |-> out_end_q, "final item does not close its component")
  `SCC_ASSERT(a_onstk_disc, (on_stk_q & ~disc_vld_q) == '0, "undiscovered vertex on stack")

endmodule
